// File: src/keyframe_rgb_animator_assert.svh
// ----------------------------------------------------------------------------
// keyframe_rgb_animator assertion macros
// Shared wrappers for the concurrent checks of the animator.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_RGB_ANIMATOR_ASSERT_SVH
`define KEYFRAME_RGB_ANIMATOR_ASSERT_SVH

// check that is switched off while reset is held
`define KRA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property violated");

// check that also holds across reset
`define KRA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property violated");

`endif

// File: src/kra_pkg.sv
// ----------------------------------------------------------------------------
// kra_pkg
// Widths, register codes and shared types of the keyframe RGB animator.
// ----------------------------------------------------------------------------
package kra_pkg;

    // sizes
    localparam int MAX_FRAMES = 6;
    localparam int TIME_W     = 32;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 3 * CHAN_W;
    localparam int FRAME_W    = TIME_W + RGB_W;
    localparam int IDX_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = FRAME_W;

    // divider: quotient bits kept before saturation, two per step
    localparam int QUO_W      = 10;
    localparam int DIV_STEPS  = QUO_W / 2;
    localparam int NUM_W      = CHAN_W + TIME_W;
    localparam int DEN_W      = TIME_W + QUO_W;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // register indexes
    localparam t_cfg_idx REG_FRAME_COUNT = t_cfg_idx'(0);
    localparam t_cfg_idx REG_PERIOD      = t_cfg_idx'(1);
    localparam t_cfg_idx REG_FRAME_0     = t_cfg_idx'(2);

    // frame count limits and reset value
    localparam t_idx MIN_COUNT = t_idx'(2);
    localparam t_idx MAX_COUNT = t_idx'(MAX_FRAMES);
    localparam t_idx COUNT_RST = t_idx'(2);

    // input commands
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // one interpolation job handed from front to back
    typedef struct packed {
        t_idx                    idx;
        logic [RGB_W-1:0]        last_rgb;
        logic [RGB_W-1:0]        next_rgb;
        logic signed [TIME_W:0]  span;
        logic signed [TIME_W:0]  offs;
    } t_job;

    typedef struct packed {
        logic vld;
        t_job job;
    } t_job_req;

endpackage

// File: src/kra_intf.sv
// ----------------------------------------------------------------------------
// kra_intf
// Valid/ready channels of the animator: command words in, colour words out.
// ----------------------------------------------------------------------------
interface kra_in_if import kra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output cmd, output now_ms, input ready);
    modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface kra_out_if import kra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    t_idx              current_frame;

    modport source (output valid, output red, output green, output blue,
                    output current_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input current_frame, output ready);
endinterface

// File: src/kra_fifo.sv
// ----------------------------------------------------------------------------
// kra_fifo
// Two-entry job queue between the timing front end and the colour back end.
// ----------------------------------------------------------------------------
module kra_fifo import kra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job_req i_push,
    input  logic     i_pop,
    output logic     o_full,
    output t_job_req o_head
);

    t_job       r_data [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push.vld) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push.vld, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_data[r_wr_ptr] <= i_push.job;
        end
    end

    assign o_full     = r_cnt[1];
    assign o_head.vld = (r_cnt != 2'd0);
    assign o_head.job = r_data[r_rd_ptr];

endmodule

// File: src/kra_front.sv
// ----------------------------------------------------------------------------
// kra_front
// Takes command words, keeps the keyframe table, start time and frame index,
// and turns each tick into an interpolation job for the back end.
// ----------------------------------------------------------------------------
module kra_front import kra_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    kra_in_if.sink           i_in,
    input  logic             i_q_full,
    output t_job_req         o_push
);

    typedef enum logic [1:0] {S_IDLE, S_FIX, S_ADV, S_PUSH} t_state;

    t_state              r_state;
    t_idx                r_frame_count;
    logic [TIME_W-1:0]   r_period;
    logic [FRAME_W-1:0]  r_mem [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_mem_vld;
    logic [TIME_W-1:0]   r_start;
    t_idx                r_idx;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_elapsed;
    logic [FRAME_W-1:0]  r_key_a;
    logic [FRAME_W-1:0]  r_key_b;

    t_idx               w_n;
    t_idx               w_fix_idx;
    t_idx               w_inc;
    logic               w_adv;
    logic               w_wrap;
    t_idx               w_new_idx;
    t_idx               w_addr_a;
    t_idx               w_addr_b;
    logic               w_frame_we;
    t_idx               w_wr_addr;
    logic [TIME_W-1:0]  w_time_a;
    logic [TIME_W-1:0]  w_time_b;

    // clamp the frame count into the supported range
    always_comb begin
        if (r_frame_count < MIN_COUNT) begin
            w_n = MIN_COUNT;
        end else if (r_frame_count > MAX_COUNT) begin
            w_n = MAX_COUNT;
        end else begin
            w_n = r_frame_count;
        end
    end

    // stale index (count lowered) restarts from frame 0
    assign w_fix_idx = (r_idx > (w_n - t_idx'(2))) ? t_idx'(0) : r_idx;

    // frame advance: at most one step a tick, wrap on the last frame
    assign w_time_a  = r_key_a[FRAME_W-1:RGB_W];
    assign w_time_b  = r_key_b[FRAME_W-1:RGB_W];
    assign w_adv     = (r_elapsed > w_time_b);
    assign w_inc     = r_idx + t_idx'(1);
    assign w_wrap    = w_adv && (w_inc == (w_n - t_idx'(1)));
    assign w_new_idx = !w_adv ? r_idx : (w_wrap ? t_idx'(0) : w_inc);

    // keyframe table read addresses; outside the fix and advance steps they
    // stay on the current frame pair so a job waiting for the queue holds
    assign w_addr_a = (r_state == S_ADV) ? w_new_idx : r_idx;
    assign w_addr_b = (r_state == S_FIX) ? (w_fix_idx + t_idx'(1)) :
                      (r_state == S_ADV) ? (w_new_idx + t_idx'(1)) :
                                           (r_idx + t_idx'(1));

    // config writes to keyframe entries
    assign w_frame_we = i_cfg_we && (i_cfg_idx >= REG_FRAME_0);
    assign w_wr_addr  = t_idx'(i_cfg_idx - REG_FRAME_0);

    // config registers and entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= COUNT_RST;
            r_period      <= '0;
            r_mem_vld     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_COUNT: r_frame_count <= i_cfg_data[IDX_W-1:0];
                REG_PERIOD:      r_period      <= i_cfg_data[TIME_W-1:0];
                default:         r_mem_vld[w_wr_addr] <= 1'b1;
            endcase
        end
    end

    // keyframe table, registered reads; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (w_frame_we) begin
            r_mem[w_wr_addr] <= i_cfg_data;
        end
        r_key_a <= r_mem_vld[w_addr_a] ? r_mem[w_addr_a] : '0;
        r_key_b <= r_mem_vld[w_addr_b] ? r_mem[w_addr_b] : '0;
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.cmd == CMD_RESTART) begin
                            r_start <= i_in.now_ms;
                            r_idx   <= t_idx'(0);
                        end else begin
                            r_now   <= i_in.now_ms;
                            r_state <= S_FIX;
                        end
                    end
                end
                S_FIX: begin
                    r_idx     <= w_fix_idx;
                    r_elapsed <= r_now - r_start;
                    r_state   <= S_ADV;
                end
                S_ADV: begin
                    r_idx <= w_new_idx;
                    if (w_wrap) begin
                        r_start   <= r_start + r_period;
                        r_elapsed <= r_elapsed - r_period;
                    end
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // job word: colours of both frames, span and offset as exact signed values
    assign o_push.vld          = (r_state == S_PUSH) && !i_q_full;
    assign o_push.job.idx      = r_idx;
    assign o_push.job.last_rgb = r_key_a[RGB_W-1:0];
    assign o_push.job.next_rgb = r_key_b[RGB_W-1:0];
    assign o_push.job.span     = $signed({1'b0, w_time_b}) - $signed({1'b0, w_time_a});
    assign o_push.job.offs     = $signed({1'b0, r_elapsed}) - $signed({1'b0, w_time_a});

endmodule

// File: src/kra_back.sv
// ----------------------------------------------------------------------------
// kra_back
// Interpolates the three channels of a job through one shared multiplier and
// one radix-4 divider, then holds the colour word for the receiver.
// ----------------------------------------------------------------------------
module kra_back import kra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_job_req i_head,
    output logic     o_pop,
    kra_out_if.source o_out
);

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_DINIT, B_DIV, B_FIN, B_OUT} t_state;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    t_state             r_state;
    logic [1:0]         r_ch;
    logic [STEP_W-1:0]  r_step;
    logic [TIME_W-1:0]  r_s_mag;
    logic               r_s_neg;
    logic               r_s_zero;
    logic [TIME_W-1:0]  r_o_mag;
    logic               r_o_neg;
    logic [NUM_W-1:0]   r_n_mag;
    logic               r_q_neg;
    logic [CHAN_W-1:0]  r_a;
    logic [NUM_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_div;
    logic [QUO_W-1:0]   r_q;
    logic               r_sat;
    logic [CHAN_W-1:0]  r_res_r;
    logic [CHAN_W-1:0]  r_res_g;
    logic [CHAN_W-1:0]  r_res_b;
    logic               r_out_vld;
    logic [CHAN_W-1:0]  r_out_r;
    logic [CHAN_W-1:0]  r_out_g;
    logic [CHAN_W-1:0]  r_out_b;
    t_idx               r_out_frame;

    logic [CHAN_W-1:0]      w_a;
    logic [CHAN_W-1:0]      w_b;
    logic signed [CHAN_W:0] w_d;
    logic signed [CHAN_W:0] w_d_abs;
    logic [NUM_W-1:0]       w_prod;
    logic signed [TIME_W:0] w_span_abs;
    logic signed [TIME_W:0] w_offs_abs;
    logic [DEN_W-1:0]       w_d1;
    logic [DEN_W-1:0]       w_d2;
    logic                   w_b1;
    logic                   w_b0;
    logic [NUM_W-1:0]       w_t;
    logic [NUM_W-1:0]       w_rem_nx;
    logic [QUO_W:0]         w_qadj;
    logic signed [QUO_W+1:0] w_qpos;
    logic signed [QUO_W+1:0] w_qs;
    logic signed [QUO_W+1:0] w_sum;
    logic [CHAN_W-1:0]      w_val;
    logic                   w_out_free;

    // channel select from the job at the queue head
    always_comb begin
        case (r_ch)
            CH_RED: begin
                w_a = i_head.job.last_rgb[RGB_W-1 -: CHAN_W];
                w_b = i_head.job.next_rgb[RGB_W-1 -: CHAN_W];
            end
            CH_GREEN: begin
                w_a = i_head.job.last_rgb[2*CHAN_W-1 -: CHAN_W];
                w_b = i_head.job.next_rgb[2*CHAN_W-1 -: CHAN_W];
            end
            default: begin
                w_a = i_head.job.last_rgb[CHAN_W-1:0];
                w_b = i_head.job.next_rgb[CHAN_W-1:0];
            end
        endcase
    end

    // colour difference and product magnitude
    assign w_d     = $signed({1'b0, w_b}) - $signed({1'b0, w_a});
    assign w_d_abs = w_d[CHAN_W] ? -w_d : w_d;
    assign w_prod  = {{TIME_W{1'b0}}, w_d_abs[CHAN_W-1:0]} * {{CHAN_W{1'b0}}, r_o_mag};

    // magnitudes of span and offset
    assign w_span_abs = i_head.job.span[TIME_W] ? -i_head.job.span : i_head.job.span;
    assign w_offs_abs = i_head.job.offs[TIME_W] ? -i_head.job.offs : i_head.job.offs;

    // two restoring divide steps a cycle
    assign w_d1     = r_div >> 1;
    assign w_d2     = r_div >> 2;
    assign w_b1     = ({2'b00, r_rem} >= w_d1);
    assign w_t      = w_b1 ? (r_rem - w_d1[NUM_W-1:0]) : r_rem;
    assign w_b0     = ({2'b00, w_t} >= w_d2);
    assign w_rem_nx = w_b0 ? (w_t - w_d2[NUM_W-1:0]) : w_t;

    // floor correction, sign, add to base colour, clamp to 0..255
    assign w_qadj = {1'b0, r_q} + {{QUO_W{1'b0}}, (r_q_neg && (r_rem != '0))};
    assign w_qpos = $signed({1'b0, w_qadj});
    assign w_qs   = r_q_neg ? -w_qpos : w_qpos;
    assign w_sum  = $signed({{(QUO_W+2-CHAN_W){1'b0}}, r_a}) + w_qs;

    always_comb begin
        if (r_s_zero) begin
            w_val = r_a;
        end else if (r_sat) begin
            w_val = r_q_neg ? '0 : '1;
        end else if (w_sum < 0) begin
            w_val = '0;
        end else if (w_sum > $signed((QUO_W+2)'(255))) begin
            w_val = '1;
        end else begin
            w_val = w_sum[CHAN_W-1:0];
        end
    end

    assign w_out_free = !r_out_vld || o_out.ready;

    // per-channel sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_ch      <= CH_RED;
            r_step    <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_head.vld) begin
                        r_s_mag  <= w_span_abs[TIME_W-1:0];
                        r_s_neg  <= i_head.job.span[TIME_W];
                        r_s_zero <= (i_head.job.span == '0);
                        r_o_mag  <= w_offs_abs[TIME_W-1:0];
                        r_o_neg  <= i_head.job.offs[TIME_W];
                        r_ch     <= CH_RED;
                        r_state  <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_n_mag <= w_prod;
                    r_q_neg <= w_d[CHAN_W] ^ r_o_neg ^ r_s_neg;
                    r_a     <= w_a;
                    r_state <= B_DINIT;
                end
                B_DINIT: begin
                    r_rem   <= r_n_mag;
                    r_div   <= {r_s_mag, {QUO_W{1'b0}}};
                    r_sat   <= ({2'b00, r_n_mag} >= {r_s_mag, {QUO_W{1'b0}}});
                    r_q     <= '0;
                    r_step  <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rem  <= w_rem_nx;
                    r_div  <= r_div >> 2;
                    r_q    <= {r_q[QUO_W-3:0], w_b1, w_b0};
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= B_FIN;
                    end
                end
                B_FIN: begin
                    case (r_ch)
                        CH_RED: begin
                            r_res_r <= w_val;
                            r_ch    <= CH_GREEN;
                            r_state <= B_MUL;
                        end
                        CH_GREEN: begin
                            r_res_g <= w_val;
                            r_ch    <= CH_BLUE;
                            r_state <= B_MUL;
                        end
                        default: begin
                            r_res_b <= w_val;
                            r_state <= B_OUT;
                        end
                    endcase
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_out_r     <= r_res_r;
                        r_out_g     <= r_res_g;
                        r_out_b     <= r_res_b;
                        r_out_frame <= i_head.job.idx;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // output word valid: set when a word is loaded, cleared when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_pop) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // the job leaves the queue once its colour word enters the output stage
    assign o_pop = (r_state == B_OUT) && w_out_free;

    assign o_out.valid         = r_out_vld;
    assign o_out.red           = r_out_r;
    assign o_out.green         = r_out_g;
    assign o_out.blue          = r_out_b;
    assign o_out.current_frame = r_out_frame;

endmodule

// File: src/keyframe_rgb_animator.sv
// ----------------------------------------------------------------------------
// keyframe_rgb_animator
// Looping keyframe colour animation with linear RGB interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   Load frame_count, period and frame_0..frame_5 through the write port
//   (i_cfg_we/i_cfg_idx/i_cfg_data) while the block is idle.
//   i_in carries command words: a restart word latches now_ms as the start
//   and clears the frame index, and gives no colour word; a tick word gives
//   one colour word on o_out (red, green, blue, current_frame).
//   A tick passes the front end's fix, advance and push steps and is queued
//   (2 jobs deep); the back end then works on it one channel at a time
//   through the shared multiplier and radix-4 divider. The front end can
//   take the next tick while the back end is still busy with the last one.
//   When o_out stalls the colour word is held, the back end finishes the
//   next job, the queue fills and then i_in.ready drops.
//   Reset (synchronous, active low) restores frame_count 2, period 0, all
//   keyframes zero, start time 0 and frame index 0, and drops o_out.valid.
// ----------------------------------------------------------------------------
module keyframe_rgb_animator import kra_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    kra_in_if.sink           i_in,
    kra_out_if.source        o_out
);

    t_job_req w_push;
    t_job_req w_head;
    logic     w_q_full;
    logic     w_pop;

    // command handling and frame timing
    kra_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_q_full),
        .o_push     (w_push)
    );

    // job queue
    kra_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_head  (w_head)
    );

    // interpolation
    kra_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// File: src/kra_checker.sv
// ----------------------------------------------------------------------------
// kra_checker
// Port-level checks of the keyframe RGB animator, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_rgb_animator_assert.svh"

module kra_checker import kra_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_cmd,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CHAN_W-1:0] i_red,
    input logic [CHAN_W-1:0] i_green,
    input logic [CHAN_W-1:0] i_blue,
    input t_idx              i_current_frame
);

    // reset empties the output stage
    `KRA_ASSERT_ALWAYS(a_rst_clears_out, i_clk, !i_rst_n |=> !i_out_valid)

    // a colour always starts from a frame that has a successor
    `KRA_ASSERT(a_frame_range, i_clk, i_rst_n, i_out_valid |-> (i_current_frame <= t_idx'(MAX_FRAMES - 2)))

    // a tick keeps the front end busy in the following cycle
    `KRA_ASSERT(a_tick_busy, i_clk, i_rst_n, (i_in_valid && i_in_ready && (i_in_cmd == CMD_TICK)) |=> !i_in_ready)

    // a stalled colour word stays put
    `KRA_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_current_frame)))

endmodule

bind keyframe_rgb_animator kra_checker u_kra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_cmd        (i_in.cmd),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_red           (o_out.red),
    .i_green         (o_out.green),
    .i_blue          (o_out.blue),
    .i_current_frame (o_out.current_frame)
);
